// ===== hdl/mtf_pkg.sv =====
`default_nettype none

package mtf_pkg;

  localparam int CACHE_SLOTS_DEF = 16;

  localparam int REQ_W      = 2;
  localparam int DEV_W      = 8;
  localparam int START_W    = 63;
  localparam int LEN_W      = 25;
  localparam int HANDLE_W   = 16;
  localparam int SLOT_OUT_W = 4;
  localparam int KILL_OUT_W = 5;
  localparam int TOTAL_W    = 32;
  localparam int CFG_W      = 5;

  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(16);

  localparam int ENTRY_W     = DEV_W + START_W + LEN_W + HANDLE_W;
  localparam int IN_TDATA_W  = ((ENTRY_W + 7) / 8) * 8;
  localparam int OUT_BITS    = 2 + 2 * HANDLE_W + 2 * SLOT_OUT_W + KILL_OUT_W + 5 * TOTAL_W;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  // Tag entry; the device sits in the low bits, as on the input stream.
  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic [LEN_W-1:0]    length;
    logic [START_W-1:0]  start;
    logic [DEV_W-1:0]    device;
  } slot_entry_t;

  typedef struct packed {
    logic key_eq;
    logic dev_eq;
    logic overlap;
  } cmp_t;

  typedef enum logic [REQ_W-1:0] {
    REQ_FIND = 2'd0,
    REQ_ADD  = 2'd1,
    REQ_KILL = 2'd2
  } req_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FIND,
    ST_ADD,
    ST_KILL,
    ST_EVICT,
    ST_EVWAIT,
    ST_SHIFT,
    ST_FRONT,
    ST_DONE
  } state_e;

  function automatic int idx_width(int n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/mtf_ram.sv =====
`default_nettype none

module mtf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [mtf_pkg::idx_width(DEPTH)-1:0]  waddr_i,
  input  logic [WIDTH-1:0]                      wdata_i,
  input  logic [mtf_pkg::idx_width(DEPTH)-1:0]  raddr_i,
  output logic [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== hdl/mtf_cmp.sv =====
`default_nettype none

module mtf_cmp (
  input  mtf_pkg::slot_entry_t entry_i,
  input  mtf_pkg::slot_entry_t key_i,
  output mtf_pkg::cmp_t        cmp_o
);
  import mtf_pkg::*;

  logic [START_W:0] entry_lo;
  logic [START_W:0] entry_end;
  logic [START_W:0] key_lo;
  logic [START_W:0] key_end;

  // Ranges overlap when entry start < key end and entry end > key start
  // (ends exclusive, one bit wider so nothing wraps).
  assign entry_lo  = {1'b0, entry_i.start};
  assign entry_end = {1'b0, entry_i.start} + (START_W + 1)'(entry_i.length);
  assign key_lo    = {1'b0, key_i.start};
  assign key_end   = {1'b0, key_i.start} + (START_W + 1)'(key_i.length);

  assign cmp_o.dev_eq  = (entry_i.device == key_i.device);
  assign cmp_o.key_eq  = cmp_o.dev_eq && (entry_i.start == key_i.start) &&
                         (entry_i.length == key_i.length);
  assign cmp_o.overlap = (entry_lo < key_end) && (entry_end > key_lo);

endmodule

`default_nettype wire

// ===== hdl/move_to_front_block_cache_tags.sv =====
`default_nettype none

// Tag store for a small disk-block cache, kept in most-recently-used order.
// Each input transfer carries one request (tuser: 0 find, 1 add, 2 kill) and
// yields exactly one output transfer with the per-request fields and the five
// running totals (reads, writes, hits, entries killed, entry moves; all wrap
// at 32 bits). A find walks the slots in use from slot 0; on a hit the entry
// is rotated to slot 0 and its buffer handle returned. An add fills the lowest
// empty slot, or drops the last slot, shifts everything down and puts the new
// entry in slot 0. A kill empties every entry of the device whose byte range
// overlaps the request range. Tags sit in one single-port-write tag RAM that
// gives one registered read a cycle, and one compare unit checks one slot per
// cycle, so a request's time grows with the slots it walks. A find hit away
// from slot 0 moves the entries before it down one slot and an evicting add
// moves all but the dropped last slot down, before slot 0 is written. The
// input is not ready while a request is in work; a finished result waits in
// the output register and the next request is taken meanwhile. slots_in_use
// (cfg_wdata_i, 0 acts as 1, values above CACHE_SLOTS clamp) resets to 16; it
// must be written only while idle, which the block itself does not enforce.
// Valid marks clear at reset; slot contents need no clearing.
module move_to_front_block_cache_tags #(
  parameter int CACHE_SLOTS = mtf_pkg::CACHE_SLOTS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // device_id[7:0], start_byte[70:8], length_bytes[95:71], buffer_handle[111:96]
  input  logic [mtf_pkg::IN_TDATA_W-1:0]   s_axis_tdata_i,
  // req_type[1:0]
  input  logic [mtf_pkg::REQ_W-1:0]        s_axis_tuser_i,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // hit[0], hit_handle[16:1], hit_slot[20:17], evicted[21],
  // evicted_handle[37:22], stored_slot[41:38], killed_count[46:42],
  // read_total[78:47], write_total[110:79], hit_total[142:111],
  // kill_total[174:143], move_total[206:175], zero[207]
  output logic [mtf_pkg::OUT_TDATA_W-1:0]  m_axis_tdata_o,
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  input  logic                             cfg_we_i,
  input  logic [mtf_pkg::CFG_W-1:0]        cfg_wdata_i
);
  import mtf_pkg::*;

  localparam int IDX_W = idx_width(CACHE_SLOTS);
  localparam int CNT_W = $clog2(CACHE_SLOTS + 1);

  state_e state_q, state_d;

  logic [CFG_W-1:0]       cfg_q;
  logic [CACHE_SLOTS-1:0] valid_q, valid_d;

  // walk control
  logic [CNT_W-1:0] idx_q, idx_d;
  logic             pend_q, pend_d;
  logic [IDX_W-1:0] pidx_q, pidx_d;
  logic             rdon_q, rdon_d;
  logic [IDX_W-1:0] last_q, last_d;

  slot_entry_t         key_q, key_d;
  logic [HANDLE_W-1:0] fhandle_q, fhandle_d;

  // per-request result fields
  logic                  hit_q, hit_d;
  logic [HANDLE_W-1:0]   hhandle_q, hhandle_d;
  logic [SLOT_OUT_W-1:0] hslot_q, hslot_d;
  logic                  evicted_q, evicted_d;
  logic [HANDLE_W-1:0]   ehandle_q, ehandle_d;
  logic [SLOT_OUT_W-1:0] sslot_q, sslot_d;
  logic [CNT_W-1:0]      killed_q, killed_d;

  logic [TOTAL_W-1:0] reads_q, reads_d;
  logic [TOTAL_W-1:0] writes_q, writes_d;
  logic [TOTAL_W-1:0] hits_q, hits_d;
  logic [TOTAL_W-1:0] kills_q, kills_d;
  logic [TOTAL_W-1:0] moves_q, moves_d;

  logic                   m_valid_q, m_valid_d;
  logic [OUT_TDATA_W-1:0] m_data_q, m_data_d;

  // tag RAM port
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  slot_entry_t      ram_wdata;
  logic [IDX_W-1:0] ram_raddr;
  slot_entry_t      ram_rdata;

  cmp_t             cmp;

  logic [CNT_W-1:0] live;
  logic [IDX_W-1:0] last_slot;
  logic             issue;
  logic [IDX_W-1:0] add_idx;

  // clamp the slot count: zero acts as one, too large acts as CACHE_SLOTS
  always_comb begin
    if (cfg_q == '0) begin
      live = CNT_W'(1);
    end else if (32'(cfg_q) > 32'(CACHE_SLOTS)) begin
      live = CNT_W'(CACHE_SLOTS);
    end else begin
      live = CNT_W'(cfg_q);
    end
  end

  assign last_slot = IDX_W'(live - 1'b1);
  assign issue     = (idx_q < live);
  assign add_idx   = idx_q[IDX_W-1:0];

  mtf_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CACHE_SLOTS)
  ) u_tag_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  mtf_cmp u_cmp (
    .entry_i (ram_rdata),
    .key_i   (key_q),
    .cmp_o   (cmp)
  );

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

  always_comb begin
    state_d   = state_q;
    valid_d   = valid_q;
    idx_d     = idx_q;
    pend_d    = pend_q;
    pidx_d    = pidx_q;
    rdon_d    = rdon_q;
    last_d    = last_q;
    key_d     = key_q;
    fhandle_d = fhandle_q;
    hit_d     = hit_q;
    hhandle_d = hhandle_q;
    hslot_d   = hslot_q;
    evicted_d = evicted_q;
    ehandle_d = ehandle_q;
    sslot_d   = sslot_q;
    killed_d  = killed_q;
    reads_d   = reads_q;
    writes_d  = writes_q;
    hits_d    = hits_q;
    kills_d   = kills_q;
    moves_d   = moves_q;
    m_data_d  = m_data_q;
    m_valid_d = m_valid_q && !m_axis_tready_i;

    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = key_q;
    ram_raddr = idx_q[IDX_W-1:0];

    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid_i) begin
          key_d     = slot_entry_t'(s_axis_tdata_i[ENTRY_W-1:0]);
          idx_d     = '0;
          pend_d    = 1'b0;
          hit_d     = 1'b0;
          hhandle_d = '0;
          hslot_d   = '0;
          evicted_d = 1'b0;
          ehandle_d = '0;
          sslot_d   = '0;
          killed_d  = '0;
          case (req_e'(s_axis_tuser_i))
            REQ_FIND: begin
              reads_d = reads_q + 32'd1;
              state_d = ST_FIND;
            end
            REQ_ADD: begin
              state_d = ST_ADD;
            end
            REQ_KILL: begin
              writes_d = writes_q + 32'd1;
              state_d  = ST_KILL;
            end
            default: begin
              state_d = ST_DONE;
            end
          endcase
        end
      end

      ST_FIND: begin
        // advance the read pointer; compare the slot read last cycle
        pend_d = issue;
        pidx_d = idx_q[IDX_W-1:0];
        if (issue) begin
          idx_d = idx_q + 1'b1;
        end
        if (pend_q && valid_q[pidx_q] && cmp.key_eq) begin
          hit_d     = 1'b1;
          hhandle_d = ram_rdata.handle;
          hslot_d   = SLOT_OUT_W'(pidx_q);
          hits_d    = hits_q + 32'd1;
          fhandle_d = ram_rdata.handle;
          last_d    = pidx_q;
          if (pidx_q != '0) begin
            idx_d   = CNT_W'(pidx_q) - 1'b1;
            rdon_d  = 1'b1;
            pend_d  = 1'b0;
            state_d = ST_SHIFT;
          end else begin
            state_d = ST_DONE;
          end
        end else if (pend_q && (pidx_q == last_slot)) begin
          state_d = ST_DONE;
        end
      end

      ST_KILL: begin
        pend_d = issue;
        pidx_d = idx_q[IDX_W-1:0];
        if (issue) begin
          idx_d = idx_q + 1'b1;
        end
        if (pend_q && valid_q[pidx_q] && cmp.dev_eq && cmp.overlap) begin
          valid_d[pidx_q] = 1'b0;
          killed_d        = killed_q + 1'b1;
        end
        if (pend_q && (pidx_q == last_slot)) begin
          kills_d = kills_q + TOTAL_W'(killed_d);
          state_d = ST_DONE;
        end
      end

      ST_ADD: begin
        // fill the lowest empty slot in place
        if (!valid_q[add_idx]) begin
          ram_we           = 1'b1;
          ram_waddr        = add_idx;
          ram_wdata        = key_q;
          valid_d[add_idx] = 1'b1;
          sslot_d          = SLOT_OUT_W'(add_idx);
          state_d          = ST_DONE;
        end else if (add_idx == last_slot) begin
          evicted_d = 1'b1;
          state_d   = ST_EVICT;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end

      ST_EVICT: begin
        ram_raddr = last_slot;
        last_d    = last_slot;
        fhandle_d = key_q.handle;
        state_d   = ST_EVWAIT;
      end

      ST_EVWAIT: begin
        ehandle_d = ram_rdata.handle;
        if (last_q == '0) begin
          state_d = ST_FRONT;
        end else begin
          idx_d   = CNT_W'(last_q) - 1'b1;
          rdon_d  = 1'b1;
          pend_d  = 1'b0;
          state_d = ST_SHIFT;
        end
      end

      ST_SHIFT: begin
        // read slot k-1 while writing the slot read last cycle one place down
        pend_d = rdon_q;
        pidx_d = idx_q[IDX_W-1:0];
        if (rdon_q) begin
          if (idx_q == '0) begin
            rdon_d = 1'b0;
          end else begin
            idx_d = idx_q - 1'b1;
          end
        end
        if (pend_q) begin
          ram_we    = 1'b1;
          ram_waddr = pidx_q + 1'b1;
          ram_wdata = ram_rdata;
          if (pidx_q == '0) begin
            state_d = ST_FRONT;
          end
        end
      end

      ST_FRONT: begin
        ram_we           = 1'b1;
        ram_waddr        = '0;
        ram_wdata        = key_q;
        ram_wdata.handle = fhandle_q;
        for (int k = 1; k < CACHE_SLOTS; k++) begin
          if (k <= int'(last_q)) begin
            valid_d[k] = valid_q[k-1];
          end
        end
        valid_d[0] = 1'b1;
        moves_d    = moves_q + TOTAL_W'(last_q);
        state_d    = ST_DONE;
      end

      ST_DONE: begin
        // hold until the output register is free
        if (!m_valid_q || m_axis_tready_i) begin
          m_valid_d = 1'b1;
          m_data_d  = {1'b0, moves_q, kills_q, hits_q, writes_q, reads_q,
                       KILL_OUT_W'(killed_q), sslot_q, ehandle_q, evicted_q,
                       hslot_q, hhandle_q, hit_q};
          state_d   = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cfg_q     <= CFG_RESET;
      valid_q   <= '0;
      idx_q     <= '0;
      pend_q    <= 1'b0;
      rdon_q    <= 1'b0;
      reads_q   <= '0;
      writes_q  <= '0;
      hits_q    <= '0;
      kills_q   <= '0;
      moves_q   <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
      valid_q   <= valid_d;
      idx_q     <= idx_d;
      pend_q    <= pend_d;
      rdon_q    <= rdon_d;
      reads_q   <= reads_d;
      writes_q  <= writes_d;
      hits_q    <= hits_d;
      kills_q   <= kills_d;
      moves_q   <= moves_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pidx_q    <= pidx_d;
    last_q    <= last_d;
    key_q     <= key_d;
    fhandle_q <= fhandle_d;
    hit_q     <= hit_d;
    hhandle_q <= hhandle_d;
    hslot_q   <= hslot_d;
    evicted_q <= evicted_d;
    ehandle_q <= ehandle_d;
    sslot_q   <= sslot_d;
    killed_q  <= killed_d;
    m_data_q  <= m_data_d;
  end

endmodule

`default_nettype wire

// ===== hdl/mtf_chk.sv =====
`default_nettype none

module mtf_chk (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire [mtf_pkg::IN_TDATA_W-1:0]   s_axis_tdata_i,
  input  wire [mtf_pkg::REQ_W-1:0]        s_axis_tuser_i,
  input  wire                             s_axis_tvalid_i,
  input  wire                             s_axis_tready_o,
  input  wire [mtf_pkg::OUT_TDATA_W-1:0]  m_axis_tdata_o,
  input  wire                             m_axis_tvalid_o,
  input  wire                             m_axis_tready_i,
  input  wire                             cfg_we_i,
  input  wire [mtf_pkg::CFG_W-1:0]        cfg_wdata_i
);

  // one request in work at a time: drop ready right after a transfer
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("input ready while a request is in work");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("stalled result changed");

  // a hit never comes with an eviction or a kill count
  a_hit_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[0] |->
      !m_axis_tdata_o[21] && (m_axis_tdata_o[46:42] == 5'd0))
    else $error("hit result carries add or kill fields");

  // an eviction always stores at the front
  a_evict_front: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[21] |-> (m_axis_tdata_o[41:38] == 4'd0))
    else $error("evicting add stored away from slot 0");

  // unused by the checks above, kept visible for waveform debug
  logic unused_inputs;
  assign unused_inputs = ^{s_axis_tdata_i, s_axis_tuser_i, cfg_we_i, cfg_wdata_i};

endmodule

bind move_to_front_block_cache_tags mtf_chk u_mtf_chk (.*);

`default_nettype wire

// ===== bench/cache_tags_checker.sv =====
`timescale 1ns / 100ps

module cache_tags_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // device_id, start_byte, length_bytes, buffer_handle (low bits up)
  input  logic [mtf_pkg::IN_TDATA_W-1:0]   req_tdata_i,
  // req_type
  input  logic [mtf_pkg::REQ_W-1:0]        req_tuser_i,
  input  logic                             req_tvalid_i,
  input  logic                             req_tready_i,
  // hit, hit_handle, hit_slot, evicted, evicted_handle, stored_slot,
  // killed_count, read/write/hit/kill/move totals, zero pad (low bits up)
  input  logic [mtf_pkg::OUT_TDATA_W-1:0]  rsp_tdata_i,
  input  logic                             rsp_tvalid_i,
  input  logic                             rsp_tready_i,
  input  logic                             cfg_we_i,
  input  logic [mtf_pkg::CFG_W-1:0]        cfg_wdata_i,
  output int                               results_due_o,
  output int                               mismatches_o
);

  import mtf_pkg::*;

  localparam int CACHE_SLOTS = CACHE_SLOTS_DEF;

  typedef struct packed {
    logic                  pad;
    logic [TOTAL_W-1:0]    move_total;
    logic [TOTAL_W-1:0]    kill_total;
    logic [TOTAL_W-1:0]    hit_total;
    logic [TOTAL_W-1:0]    write_total;
    logic [TOTAL_W-1:0]    read_total;
    logic [KILL_OUT_W-1:0] killed_count;
    logic [SLOT_OUT_W-1:0] stored_slot;
    logic [HANDLE_W-1:0]   evicted_handle;
    logic                  evicted;
    logic [SLOT_OUT_W-1:0] hit_slot;
    logic [HANDLE_W-1:0]   hit_handle;
    logic                  hit;
  } tag_result_t;

  // Shadow copy of the tag store.
  logic                 slot_ok [CACHE_SLOTS];
  slot_entry_t          slot_tag[CACHE_SLOTS];
  logic [CFG_W-1:0]     slot_limit;
  logic [TOTAL_W-1:0]   reads_total, writes_total, hits_total, kills_total, moves_total;

  tag_result_t due_results[$];
  int          mismatch_count = 0;
  int          results_seen   = 0;

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    mismatch_count++;
    $display("%0t: result %0d, %s: got %0h, want %0h", $time, results_seen, what, got, want);
  endtask

  task automatic check_field(string what, logic [63:0] got, logic [63:0] want);
    if (got !== want) report(what, got, want);
  endtask

  // Move entries 0..last-1 down one place and put the entry at the front.
  function automatic void shift_down(int last, slot_entry_t front);
    for (int j = last; j > 0; j--) begin
      slot_ok[j]  = slot_ok[j-1];
      slot_tag[j] = slot_tag[j-1];
    end
    slot_ok[0]  = 1'b1;
    slot_tag[0] = front;
  endfunction

  function automatic tag_result_t predict_request(logic [REQ_W-1:0] kind, slot_entry_t req);
    tag_result_t r;
    int          n;
    bit          done;
    logic [63:0] killed;
    logic [63:0] es, el, st, ln;
    r      = '0;
    done   = 1'b0;
    killed = '0;
    n = (slot_limit == 0) ? 1 : (slot_limit > CACHE_SLOTS) ? CACHE_SLOTS : int'(slot_limit);
    case (kind)
      REQ_FIND: begin
        reads_total = reads_total + 1;
        for (int k = 0; k < n; k++) begin
          if (!done && slot_ok[k] && slot_tag[k].device == req.device &&
              slot_tag[k].start == req.start && slot_tag[k].length == req.length) begin
            done         = 1'b1;
            r.hit        = 1'b1;
            r.hit_handle = slot_tag[k].handle;
            r.hit_slot   = SLOT_OUT_W'(k);
            if (k != 0) begin
              shift_down(k, slot_tag[k]);
              moves_total = moves_total + TOTAL_W'(k);
            end
            hits_total = hits_total + 1;
          end
        end
      end
      REQ_ADD: begin
        for (int k = 0; k < n; k++) begin
          if (!done && !slot_ok[k]) begin
            done          = 1'b1;
            slot_ok[k]    = 1'b1;
            slot_tag[k]   = req;
            r.stored_slot = SLOT_OUT_W'(k);
          end
        end
        if (!done) begin
          // full: drop the last slot in use, push the new entry in front
          r.evicted        = 1'b1;
          r.evicted_handle = slot_tag[n-1].handle;
          shift_down(n - 1, req);
          moves_total = moves_total + TOTAL_W'(n - 1);
        end
      end
      REQ_KILL: begin
        writes_total = writes_total + 1;
        st = 64'(req.start);
        ln = 64'(req.length);
        for (int k = 0; k < n; k++) begin
          if (slot_ok[k] && slot_tag[k].device == req.device) begin
            es = 64'(slot_tag[k].start);
            el = 64'(slot_tag[k].length);
            if (es + 1 <= st + ln && es + el >= st + 1) begin
              slot_ok[k] = 1'b0;
              killed     = killed + 1;
            end
          end
        end
        kills_total    = kills_total + TOTAL_W'(killed);
        r.killed_count = KILL_OUT_W'(killed);
      end
      default: ;
    endcase
    r.read_total  = reads_total;
    r.write_total = writes_total;
    r.hit_total   = hits_total;
    r.kill_total  = kills_total;
    r.move_total  = moves_total;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    tag_result_t got, want;
    if (!rst_ni) begin
      for (int k = 0; k < CACHE_SLOTS; k++) slot_ok[k] = 1'b0;
      slot_limit   = CFG_RESET;
      reads_total  = '0;
      writes_total = '0;
      hits_total   = '0;
      kills_total  = '0;
      moves_total  = '0;
      due_results.delete();
      results_due_o <= 0;
    end else begin
      if (cfg_we_i) slot_limit = cfg_wdata_i;
      // Results leave before this edge's request is predicted.
      if (rsp_tvalid_i && rsp_tready_i) begin
        got = rsp_tdata_i;
        if (due_results.size() == 0) begin
          report("unexpected result", got[63:0], '0);
        end else begin
          want = due_results.pop_front();
          check_field("hit", got.hit, want.hit);
          check_field("hit_handle", got.hit_handle, want.hit_handle);
          check_field("hit_slot", got.hit_slot, want.hit_slot);
          check_field("evicted", got.evicted, want.evicted);
          check_field("evicted_handle", got.evicted_handle, want.evicted_handle);
          check_field("stored_slot", got.stored_slot, want.stored_slot);
          check_field("killed_count", got.killed_count, want.killed_count);
          check_field("read_total", got.read_total, want.read_total);
          check_field("write_total", got.write_total, want.write_total);
          check_field("hit_total", got.hit_total, want.hit_total);
          check_field("kill_total", got.kill_total, want.kill_total);
          check_field("move_total", got.move_total, want.move_total);
        end
        results_seen++;
      end
      if (req_tvalid_i && req_tready_i)
        due_results.push_back(predict_request(req_tuser_i, slot_entry_t'(req_tdata_i)));
      results_due_o <= due_results.size();
    end
    mismatches_o <= mismatch_count;
  end

endmodule

// ===== bench/move_to_front_block_cache_tags_tb.sv =====
`timescale 1ns / 100ps

module move_to_front_block_cache_tags_tb;

  import mtf_pkg::*;

  // req_type 3 is not a request; the block only reports the totals for it.
  localparam logic [REQ_W-1:0]   REQ_UNKNOWN = 2'd3;
  localparam logic [START_W-1:0] START_MAX   = '1;
  localparam logic [LEN_W-1:0]   LEN_TOP     = LEN_W'(1 << 24);
  localparam int                 PHASE_ITEMS = 60;
  localparam int                 LONG_HOLD   = 300;
  localparam int                 SETTLE      = 40;
  localparam int                 CYCLE_LIMIT = 400000;
  localparam int                 POOL_DEPTH  = 32;

  logic                    clk_i;
  logic                    rst_ni;
  logic [IN_TDATA_W-1:0]   s_tdata;
  logic [REQ_W-1:0]        s_tuser;
  logic                    s_tvalid;
  logic                    s_tready;
  logic [OUT_TDATA_W-1:0]  m_tdata;
  logic                    m_tvalid;
  logic                    m_tready;
  logic                    cfg_we;
  logic [CFG_W-1:0]        cfg_wdata;

  int results_due;
  int mismatches;
  int cycles = 0;

  // Knobs shared by the sender and the receiver process.
  bit gaps_on      = 1'b0;
  bit stalls_on    = 1'b0;
  bit long_hold_rq = 1'b0;

  // Keys added recently; finds and kills aim at them so they hit.
  slot_entry_t known_keys[$];

  move_to_front_block_cache_tags uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata)
  );

  // The checker sees every transfer on both streams and every register write.
  cache_tags_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_tdata_i   (s_tdata),
    .req_tuser_i   (s_tuser),
    .req_tvalid_i  (s_tvalid),
    .req_tready_i  (s_tready),
    .rsp_tdata_i   (m_tdata),
    .rsp_tvalid_i  (m_tvalid),
    .rsp_tready_i  (m_tready),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .results_due_o (results_due),
    .mismatches_o  (mismatches)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Watchdog: stop a hung run well past the slowest legal finish.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Receiver: random stall bursts, plus one long hold-off on request so the
  // block backs up and drops tready on its input.
  initial begin
    m_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (long_hold_rq) begin
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
        long_hold_rq = 1'b0;
      end else if (stalls_on && $urandom_range(0, 2) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 4) - 1) @(posedge clk_i);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  function automatic slot_entry_t make_entry(logic [DEV_W-1:0] dev, logic [START_W-1:0] st,
                                             logic [LEN_W-1:0] len, logic [HANDLE_W-1:0] h);
    slot_entry_t e;
    e.device = dev;
    e.start  = st;
    e.length = len;
    e.handle = h;
    return e;
  endfunction

  // Mostly small devices and addresses so ranges collide; now and then the
  // full field width.
  function automatic slot_entry_t random_key();
    slot_entry_t e;
    e.device = ($urandom_range(0, 4) != 0) ? DEV_W'($urandom_range(0, 3)) : DEV_W'($urandom);
    e.start  = ($urandom_range(0, 9) < 7) ? START_W'($urandom_range(0, 4095))
                                          : START_W'({$urandom, $urandom});
    case ($urandom_range(0, 9))
      0:       e.length = LEN_W'($urandom_range(0, 1 << 24));
      1:       e.length = '0;
      default: e.length = LEN_W'($urandom_range(0, 600));
    endcase
    e.handle = HANDLE_W'($urandom);
    return e;
  endfunction

  // Present one request and hold it until the block takes it. Returns at the
  // edge of the transfer, so the next call drives right after it.
  task automatic send_request(logic [REQ_W-1:0] kind, slot_entry_t e);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= e;
    do @(posedge clk_i); while (!s_tready);
    if (kind == REQ_ADD) begin
      known_keys.push_back(e);
      if (known_keys.size() > POOL_DEPTH) void'(known_keys.pop_front());
    end
  endtask

  // Drain everything, then write the slot count while the block is idle.
  task automatic write_slot_count(logic [CFG_W-1:0] value);
    s_tvalid <= 1'b0;
    do @(posedge clk_i); while (results_due != 0);
    repeat (4) @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  task automatic random_request();
    slot_entry_t      e;
    slot_entry_t      p;
    logic [REQ_W-1:0] kind;
    int               pick;
    int               off;
    pick = $urandom_range(0, 99);
    e    = random_key();
    if (known_keys.size() != 0) p = known_keys[$urandom_range(0, known_keys.size() - 1)];
    else p = e;
    if (pick < 35) begin
      kind = REQ_ADD;
      // sometimes add a key that was added recently
      if ($urandom_range(0, 4) == 0) e = make_entry(p.device, p.start, p.length, e.handle);
    end else if (pick < 75) begin
      kind = REQ_FIND;
      if ($urandom_range(0, 9) < 7) e = make_entry(p.device, p.start, p.length, e.handle);
    end else if (pick < 95) begin
      kind = REQ_KILL;
      if ($urandom_range(0, 9) < 6) begin
        off = $urandom_range(0, 32);
        e.device = p.device;
        e.start  = (p.start > 32) ? p.start - START_W'(off) : p.start + START_W'(off);
        e.length = ($urandom_range(0, 4) == 0) ? '0 : LEN_W'($urandom_range(1, 128));
      end
    end else begin
      kind = REQ_UNKNOWN;
    end
    send_request(kind, e);
  endtask

  initial begin
    // slot counts per phase: extremes, out-of-range values and shrink/grow
    int slot_plan[9];
    slot_plan = '{1, 0, 4, 31, 16, 2, 17, 5, 16};

    rst_ni    <= 1'b0;
    s_tvalid  <= 1'b0;
    s_tuser   <= REQ_FIND;
    s_tdata   <= '0;
    cfg_we    <= 1'b0;
    cfg_wdata <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part at the reset slot count.
    send_request(REQ_FIND, make_entry('0, '0, '0, '0));                  // miss on empty store
    send_request(REQ_ADD,  make_entry('1, START_MAX, LEN_TOP, '1));      // widest values
    send_request(REQ_ADD,  make_entry('0, '0, '0, '0));                  // narrowest values
    send_request(REQ_ADD,  make_entry('0, '0, '0, 16'h0001));            // duplicate key
    send_request(REQ_FIND, make_entry('1, START_MAX, LEN_TOP, '0));      // hit at slot 0
    send_request(REQ_FIND, make_entry('0, '0, '0, '0));                  // hit at slot 1, rotate
    send_request(REQ_UNKNOWN, make_entry(8'h5a, START_W'(77), LEN_W'(3), 16'hbeef));
    // zero-length kill exactly at an entry's first byte: nothing to empty
    send_request(REQ_KILL, make_entry('1, START_MAX, '0, '0));
    send_request(REQ_ADD,  make_entry(8'd7, START_W'(1000), LEN_W'(100), 16'h1234));
    // zero-length kill inside an entry: boundary falls within it, so kill it
    send_request(REQ_KILL, make_entry(8'd7, START_W'(1050), '0, '0));
    send_request(REQ_KILL, make_entry('1, START_MAX, LEN_W'(1), '0));
    send_request(REQ_FIND, make_entry('1, START_MAX, LEN_TOP, '0));      // gone now
    send_request(REQ_KILL, make_entry('0, '0, LEN_TOP, '0));             // empty dev 0 runs stay
    send_request(REQ_ADD,  make_entry(8'h80, START_W'({32'h5555_5555, 32'haaaa_aaaa}),
                                      LEN_W'(24'haaaaaa), 16'h5555));

    // Random phases; the first gets the long receiver hold-off, the last runs
    // with no idling on either side.
    for (int ph = 0; ph < $size(slot_plan); ph++) begin
      write_slot_count(CFG_W'(slot_plan[ph]));
      gaps_on   = (ph % 3 != 2) && (ph != $size(slot_plan) - 1);
      stalls_on = gaps_on;
      if (ph == 0) long_hold_rq = 1'b1;
      for (int i = 0; i < PHASE_ITEMS; i++) random_request();
    end

    s_tvalid <= 1'b0;
    do @(posedge clk_i); while (results_due != 0);
    repeat (SETTLE) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== move_to_front_block_cache_tags.f =====
hdl/mtf_pkg.sv
hdl/mtf_ram.sv
hdl/mtf_cmp.sv
hdl/move_to_front_block_cache_tags.sv
hdl/mtf_chk.sv
bench/cache_tags_checker.sv
bench/move_to_front_block_cache_tags_tb.sv
